// ===== rtl/core/torus_point_zbuffer_shader_assert.svh =====
// Assertion macros for the torus point plotter.
`ifndef TORUS_POINT_ZBUFFER_SHADER_ASSERT_SVH
`define TORUS_POINT_ZBUFFER_SHADER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define TPZS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpzs assertion failed");

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define TPZS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpzs assertion failed");

`endif

// ===== rtl/core/tpzs_pkg.sv =====
// Shared types, constants and tables of the torus point plotter.
`timescale 1ns / 1ps
package tpzs_pkg;

  localparam int unsigned COLUMNS   = 40;
  localparam int unsigned ROWS      = 27;
  localparam int unsigned CELLS     = COLUMNS * ROWS;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned COL_W     = $clog2(COLUMNS);
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned ENTRY_W   = DEPTH_W + CODE_W;
  localparam int unsigned MUL_STEPS = 18;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned PRJ_STEPS = 4;

  localparam logic [CODE_W-1:0] SPACE_CODE  = 4'd15;
  localparam logic [7:0]        SPACE_CHAR  = 8'h20;
  localparam logic [5:0]        SCALE_RESET = 6'd15;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_PLOT  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OP_SS, OP_CS, OP_SR, OP_CR, OP_H, OP_SA, OP_CA, OP_SB, OP_CB,
    OP_SIH, OP_CIH, OP_T, OP_SCJ, OP_U, OP_W
  } opnd_e;

  typedef enum logic [3:0] {
    DST_SIH, DST_CIH, DST_DEN, DST_T, DST_PX, DST_PY, DST_SCJ, DST_U, DST_LUM, DST_W
  } dst_e;

  typedef enum logic [1:0] {
    ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD5
  } acc_e;

  typedef enum logic [1:0] {
    RES_HOLD, RES_ZERO, RES_READ, RES_PLOT
  } res_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_MEX, ST_MWB, ST_DCHK, ST_DIV, ST_PRJ,
    ST_LOOK, ST_CMP, ST_RDA, ST_RDD, ST_DONE
  } st_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    dst_e  dst;
    acc_e  acc;
  } mop_t;

  typedef struct packed {
    logic              accept;
    logic              frame_ld;
    logic              clr;
    logic [ADDR_W-1:0] cnt;
    mop_t              mop;
    logic              mul_ex;
    logic              mul_wb;
    logic              div_init;
    logic              div_step;
    logic              prj;
    logic              rd_pos;
    res_e              res;
    logic              out_ld;
  } cmd_t;

  typedef struct packed {
    logic den_bad;
    logic den_sat;
    logic in_bounds;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

  function automatic mop_t mop_table(input logic [4:0] step);
    mop_t m;
    unique case (step)
      5'd0:    m = '{a: OP_SS,  b: OP_H,  dst: DST_SIH, acc: ACC_LOAD};
      5'd1:    m = '{a: OP_CS,  b: OP_H,  dst: DST_CIH, acc: ACC_LOAD};
      5'd2:    m = '{a: OP_SIH, b: OP_SA, dst: DST_DEN, acc: ACC_LOAD};
      5'd3:    m = '{a: OP_SR,  b: OP_CA, dst: DST_DEN, acc: ACC_ADD5};
      5'd4:    m = '{a: OP_SIH, b: OP_CA, dst: DST_T,   acc: ACC_LOAD};
      5'd5:    m = '{a: OP_SR,  b: OP_SA, dst: DST_T,   acc: ACC_SUB};
      5'd6:    m = '{a: OP_CIH, b: OP_CB, dst: DST_PX,  acc: ACC_LOAD};
      5'd7:    m = '{a: OP_T,   b: OP_SB, dst: DST_PX,  acc: ACC_SUB};
      5'd8:    m = '{a: OP_CIH, b: OP_SB, dst: DST_PY,  acc: ACC_LOAD};
      5'd9:    m = '{a: OP_T,   b: OP_CB, dst: DST_PY,  acc: ACC_ADD};
      5'd10:   m = '{a: OP_SS,  b: OP_CR, dst: DST_SCJ, acc: ACC_LOAD};
      5'd11:   m = '{a: OP_SR,  b: OP_SA, dst: DST_U,   acc: ACC_LOAD};
      5'd12:   m = '{a: OP_SCJ, b: OP_CA, dst: DST_U,   acc: ACC_SUB};
      5'd13:   m = '{a: OP_CB,  b: OP_U,  dst: DST_LUM, acc: ACC_LOAD};
      5'd14:   m = '{a: OP_SCJ, b: OP_SA, dst: DST_LUM, acc: ACC_SUB};
      5'd15:   m = '{a: OP_SR,  b: OP_CA, dst: DST_LUM, acc: ACC_SUB};
      5'd16:   m = '{a: OP_CS,  b: OP_CR, dst: DST_W,   acc: ACC_LOAD};
      5'd17:   m = '{a: OP_W,   b: OP_SB, dst: DST_LUM, acc: ACC_SUB};
      default: m = '{a: OP_SS,  b: OP_SS, dst: DST_W,   acc: ACC_LOAD};
    endcase
    return m;
  endfunction

  function automatic logic [7:0] ramp_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    unique case (code)
      4'd0:    c = 8'h2E;
      4'd1:    c = 8'h2C;
      4'd2:    c = 8'h2D;
      4'd3:    c = 8'h7E;
      4'd4:    c = 8'h3A;
      4'd5:    c = 8'h3B;
      4'd6:    c = 8'h3D;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h2A;
      4'd9:    c = 8'h23;
      4'd10:   c = 8'h24;
      4'd11:   c = 8'h40;
      default: c = SPACE_CHAR;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/tpzs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tpzs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/tpzs_ctrl.sv =====
// Sequencing state machine of the torus point plotter.
`timescale 1ns / 1ps
module tpzs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [1:0]        action_i,
  input  tpzs_pkg::sts_t    sts_i,
  output tpzs_pkg::cmd_t    cmd_o
);

  localparam int unsigned AW = tpzs_pkg::ADDR_W;

  tpzs_pkg::st_e st_q, st_d;
  logic [AW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= tpzs_pkg::ST_INIT;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.cnt  = cnt_q;
    cmd_o.mop  = tpzs_pkg::mop_table(cnt_q[4:0]);
    cmd_o.res  = tpzs_pkg::RES_HOLD;
    s_tready_o = 1'b0;
    unique case (st_q)
      tpzs_pkg::ST_INIT, tpzs_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(tpzs_pkg::CELLS - 1)) begin
          cnt_d = '0;
          if (st_q == tpzs_pkg::ST_INIT) begin
            st_d = tpzs_pkg::ST_IDLE;
          end else begin
            cmd_o.res = tpzs_pkg::RES_ZERO;
            st_d      = tpzs_pkg::ST_DONE;
          end
        end
      end
      tpzs_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        cnt_d      = '0;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          unique case (tpzs_pkg::action_e'(action_i))
            tpzs_pkg::ACT_START: begin
              cmd_o.frame_ld = 1'b1;
              st_d           = tpzs_pkg::ST_CLEAR;
            end
            tpzs_pkg::ACT_PLOT: st_d = tpzs_pkg::ST_MEX;
            tpzs_pkg::ACT_READ: st_d = tpzs_pkg::ST_RDA;
            default: begin
              cmd_o.res = tpzs_pkg::RES_ZERO;
              st_d      = tpzs_pkg::ST_DONE;
            end
          endcase
        end
      end
      tpzs_pkg::ST_MEX: begin
        cmd_o.mul_ex = 1'b1;
        st_d         = tpzs_pkg::ST_MWB;
      end
      tpzs_pkg::ST_MWB: begin
        cmd_o.mul_wb = 1'b1;
        if (cnt_q == AW'(tpzs_pkg::MUL_STEPS - 1)) begin
          cnt_d = '0;
          st_d  = tpzs_pkg::ST_DCHK;
        end else begin
          cnt_d = cnt_q + AW'(1);
          st_d  = tpzs_pkg::ST_MEX;
        end
      end
      tpzs_pkg::ST_DCHK: begin
        if (sts_i.den_bad) begin
          cmd_o.res = tpzs_pkg::RES_ZERO;
          st_d      = tpzs_pkg::ST_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          st_d = sts_i.den_sat ? tpzs_pkg::ST_PRJ : tpzs_pkg::ST_DIV;
        end
      end
      tpzs_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + AW'(1);
        if (cnt_q == AW'(tpzs_pkg::DIV_STEPS - 1)) begin
          cnt_d = '0;
          st_d  = tpzs_pkg::ST_PRJ;
        end
      end
      tpzs_pkg::ST_PRJ: begin
        cmd_o.prj = 1'b1;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(tpzs_pkg::PRJ_STEPS - 1)) begin
          cnt_d = '0;
          st_d  = tpzs_pkg::ST_LOOK;
        end
      end
      tpzs_pkg::ST_LOOK: begin
        cmd_o.rd_pos = 1'b1;
        if (sts_i.in_bounds) begin
          st_d = tpzs_pkg::ST_CMP;
        end else begin
          cmd_o.res = tpzs_pkg::RES_ZERO;
          st_d      = tpzs_pkg::ST_DONE;
        end
      end
      tpzs_pkg::ST_CMP: begin
        cmd_o.rd_pos = 1'b1;
        cmd_o.res    = tpzs_pkg::RES_PLOT;
        st_d         = tpzs_pkg::ST_DONE;
      end
      tpzs_pkg::ST_RDA: st_d = tpzs_pkg::ST_RDD;
      tpzs_pkg::ST_RDD: begin
        cmd_o.res = tpzs_pkg::RES_READ;
        st_d      = tpzs_pkg::ST_DONE;
      end
      tpzs_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          st_d         = tpzs_pkg::ST_IDLE;
        end
      end
      default: st_d = tpzs_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/tpzs_dpath.sv =====
// Arithmetic datapath, store access and output register of the torus point plotter.
`timescale 1ns / 1ps
module tpzs_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [5:0]                            cfg_wdata_i,
  input  logic signed [15:0]                    sin_a_i,
  input  logic signed [15:0]                    cos_a_i,
  input  logic signed [15:0]                    sin_b_i,
  input  logic signed [15:0]                    cos_b_i,
  input  logic signed [15:0]                    sin_ring_i,
  input  logic signed [15:0]                    cos_ring_i,
  input  logic signed [15:0]                    sin_sweep_i,
  input  logic signed [15:0]                    cos_sweep_i,
  input  logic [10:0]                           cell_index_i,
  input  tpzs_pkg::cmd_t                        cmd_i,
  output tpzs_pkg::sts_t                        sts_o,
  output tpzs_pkg::ram_req_t                    ram_o,
  input  logic [tpzs_pkg::ENTRY_W-1:0]          ram_rdata_i,
  input  logic                                  m_tready_i,
  output logic                                  m_tvalid_o,
  output logic [7:0]                            m_glyph_o,
  output logic                                  m_plotted_o
);

  localparam int unsigned VW  = tpzs_pkg::VAL_W;
  localparam int unsigned PW  = 2 * VW;
  localparam int unsigned DW  = tpzs_pkg::DEPTH_W;
  localparam int unsigned CW  = tpzs_pkg::CODE_W;
  localparam int unsigned AW  = tpzs_pkg::ADDR_W;
  localparam int unsigned PDW = DW + 1 + VW;
  localparam int unsigned SW  = 9;
  localparam int unsigned XW  = PDW + SW + 2;
  localparam logic signed [PW-1:0] RND     = PW'(16383);
  localparam logic signed [VW-1:0] FIVE    = VW'(5 * 16384);
  localparam logic signed [VW-1:0] HOFF    = VW'(2 * 16384);
  localparam logic signed [VW-1:0] SAT_LIM = VW'(16384);
  localparam logic signed [VW-1:0] LUM_LO  = VW'(2048);
  localparam logic signed [VW-1:0] LUM_HI  = VW'(12 * 2048);
  localparam logic signed [XW-1:0] ONE30   = XW'(1) << 30;
  localparam logic signed [XW-1:0] OFF_X   = XW'(tpzs_pkg::COLUMNS / 2) << 30;
  localparam logic signed [XW-1:0] OFF_Y   = XW'(tpzs_pkg::ROWS / 2) << 30;
  localparam logic signed [XW-1:0] LIM_X   = XW'(tpzs_pkg::COLUMNS) << 30;
  localparam logic signed [XW-1:0] LIM_Y   = XW'(tpzs_pkg::ROWS) << 30;

  logic [5:0]               scale_q;
  logic signed [15:0]       sa_q, ca_q, sb_q, cb_q;
  logic signed [15:0]       sr_q, cr_q, ss_q, cs_q;
  logic [10:0]              ci_q;
  logic signed [VW-1:0]     sih_q, cih_q, den_q, t_q, px_q, py_q, scj_q, u_q, lum_q, w_q;
  logic signed [PW-1:0]     prod_q;
  logic [VW-1:0]            rem_q;
  logic [DW-1:0]            d_q;
  logic signed [PDW-1:0]    pd_q;
  logic [tpzs_pkg::COL_W-1:0] xi_q;
  logic [tpzs_pkg::ROW_W-1:0] yi_q;
  logic                     inx_q, iny_q;
  logic [7:0]               res_glyph_q;
  logic                     res_plot_q;
  logic                     m_valid_q;
  logic [7:0]               m_glyph_q;
  logic                     m_plot_q;

  logic signed [VW-1:0]     h, opa, opb, cur, mqv, wbv;
  logic signed [PW-1:0]     adj;
  logic [VW-1:0]            rem2;
  logic                     ge;
  logic signed [XW-1:0]     vsum;
  logic signed [SW-1:0]     scl;
  logic                     v_in;
  logic [AW-1:0]            pos;
  logic [CW-1:0]            code;
  logic                     hit;

  assign h = VW'(cr_q) + HOFF;

  function automatic logic signed [VW-1:0] pick(input tpzs_pkg::opnd_e sel,
      input logic signed [15:0] ss, input logic signed [15:0] cs,
      input logic signed [15:0] sr, input logic signed [15:0] cr,
      input logic signed [VW-1:0] hv, input logic signed [15:0] sa,
      input logic signed [15:0] ca, input logic signed [15:0] sb,
      input logic signed [15:0] cb, input logic signed [VW-1:0] sih,
      input logic signed [VW-1:0] cih, input logic signed [VW-1:0] t,
      input logic signed [VW-1:0] scj, input logic signed [VW-1:0] u,
      input logic signed [VW-1:0] w);
    logic signed [VW-1:0] r;
    unique case (sel)
      tpzs_pkg::OP_SS:  r = VW'(ss);
      tpzs_pkg::OP_CS:  r = VW'(cs);
      tpzs_pkg::OP_SR:  r = VW'(sr);
      tpzs_pkg::OP_CR:  r = VW'(cr);
      tpzs_pkg::OP_H:   r = hv;
      tpzs_pkg::OP_SA:  r = VW'(sa);
      tpzs_pkg::OP_CA:  r = VW'(ca);
      tpzs_pkg::OP_SB:  r = VW'(sb);
      tpzs_pkg::OP_CB:  r = VW'(cb);
      tpzs_pkg::OP_SIH: r = sih;
      tpzs_pkg::OP_CIH: r = cih;
      tpzs_pkg::OP_T:   r = t;
      tpzs_pkg::OP_SCJ: r = scj;
      tpzs_pkg::OP_U:   r = u;
      default:          r = w;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = pick(cmd_i.mop.a, ss_q, cs_q, sr_q, cr_q, h, sa_q, ca_q, sb_q, cb_q,
               sih_q, cih_q, t_q, scj_q, u_q, w_q);
    opb = pick(cmd_i.mop.b, ss_q, cs_q, sr_q, cr_q, h, sa_q, ca_q, sb_q, cb_q,
               sih_q, cih_q, t_q, scj_q, u_q, w_q);
    adj = prod_q + (prod_q[PW-1] ? RND : PW'(0));
    mqv = VW'(adj >>> 14);
    unique case (cmd_i.mop.dst)
      tpzs_pkg::DST_SIH: cur = sih_q;
      tpzs_pkg::DST_CIH: cur = cih_q;
      tpzs_pkg::DST_DEN: cur = den_q;
      tpzs_pkg::DST_T:   cur = t_q;
      tpzs_pkg::DST_PX:  cur = px_q;
      tpzs_pkg::DST_PY:  cur = py_q;
      tpzs_pkg::DST_SCJ: cur = scj_q;
      tpzs_pkg::DST_U:   cur = u_q;
      tpzs_pkg::DST_LUM: cur = lum_q;
      default:           cur = w_q;
    endcase
    unique case (cmd_i.mop.acc)
      tpzs_pkg::ACC_LOAD: wbv = mqv;
      tpzs_pkg::ACC_ADD:  wbv = cur + mqv;
      tpzs_pkg::ACC_SUB:  wbv = cur - mqv;
      default:            wbv = cur + mqv + FIVE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= tpzs_pkg::SCALE_RESET;
      sa_q    <= '0;
      ca_q    <= '0;
      sb_q    <= '0;
      cb_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (cmd_i.frame_ld) begin
        sa_q <= sin_a_i;
        ca_q <= cos_a_i;
        sb_q <= sin_b_i;
        cb_q <= cos_b_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sr_q <= sin_ring_i;
      cr_q <= cos_ring_i;
      ss_q <= sin_sweep_i;
      cs_q <= cos_sweep_i;
      ci_q <= cell_index_i;
    end
    if (cmd_i.mul_ex) begin
      prod_q <= opa * opb;
    end
    if (cmd_i.mul_wb) begin
      unique case (cmd_i.mop.dst)
        tpzs_pkg::DST_SIH: sih_q <= wbv;
        tpzs_pkg::DST_CIH: cih_q <= wbv;
        tpzs_pkg::DST_DEN: den_q <= wbv;
        tpzs_pkg::DST_T:   t_q   <= wbv;
        tpzs_pkg::DST_PX:  px_q  <= wbv;
        tpzs_pkg::DST_PY:  py_q  <= wbv;
        tpzs_pkg::DST_SCJ: scj_q <= wbv;
        tpzs_pkg::DST_U:   u_q   <= wbv;
        tpzs_pkg::DST_LUM: lum_q <= wbv;
        default:           w_q   <= wbv;
      endcase
    end
  end

  assign sts_o.den_bad = den_q[VW-1] || (den_q == '0);
  assign sts_o.den_sat = (den_q <= SAT_LIM);

  // Restoring divide of 2^30 by den, one quotient bit per step.
  assign rem2 = {rem_q[VW-2:0], 1'b0};
  assign ge   = (rem2 >= $unsigned(den_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= VW'(16384);
      d_q   <= sts_o.den_sat ? {DW{1'b1}} : '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (rem2 - $unsigned(den_q)) : rem2;
      d_q   <= {d_q[DW-2:0], ge};
    end
  end

  assign scl  = cmd_i.cnt[1] ? SW'({3'b000, scale_q}) : SW'({2'b00, scale_q, 1'b0});
  assign vsum = pd_q * scl + (cmd_i.cnt[1] ? OFF_Y : OFF_X);
  assign v_in = (vsum >= ONE30) && (vsum < (cmd_i.cnt[1] ? LIM_Y : LIM_X));

  always_ff @(posedge clk_i) begin
    if (cmd_i.prj) begin
      if (!cmd_i.cnt[0]) begin
        pd_q <= $signed({1'b0, d_q}) * (cmd_i.cnt[1] ? py_q : px_q);
      end else if (cmd_i.cnt[1]) begin
        iny_q <= v_in;
        yi_q  <= vsum[30 +: tpzs_pkg::ROW_W];
      end else begin
        inx_q <= v_in;
        xi_q  <= vsum[30 +: tpzs_pkg::COL_W];
      end
    end
  end

  assign sts_o.in_bounds = inx_q && iny_q;
  assign pos  = AW'(int'(yi_q) * tpzs_pkg::COLUMNS + int'(xi_q));
  assign code = ((lum_q >= LUM_LO) && (lum_q < LUM_HI)) ? lum_q[14:11] : '0;
  assign hit  = d_q > ram_rdata_i[tpzs_pkg::ENTRY_W-1:CW];

  always_comb begin
    ram_o.we    = cmd_i.clr || ((cmd_i.res == tpzs_pkg::RES_PLOT) && hit);
    ram_o.waddr = cmd_i.clr ? cmd_i.cnt : pos;
    ram_o.wdata = cmd_i.clr ? {{DW{1'b0}}, tpzs_pkg::SPACE_CODE} : {d_q, code};
    ram_o.raddr = cmd_i.rd_pos ? pos : AW'(ci_q);
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res)
      tpzs_pkg::RES_ZERO: begin
        res_glyph_q <= '0;
        res_plot_q  <= 1'b0;
      end
      tpzs_pkg::RES_READ: begin
        res_glyph_q <= (int'(ci_q) < tpzs_pkg::CELLS) ?
                       tpzs_pkg::ramp_char(ram_rdata_i[CW-1:0]) : tpzs_pkg::SPACE_CHAR;
        res_plot_q  <= 1'b0;
      end
      tpzs_pkg::RES_PLOT: begin
        res_glyph_q <= hit ? tpzs_pkg::ramp_char(code) : 8'h00;
        res_plot_q  <= hit;
      end
      default: ;
    endcase
    if (cmd_i.out_ld) begin
      m_glyph_q <= res_glyph_q;
      m_plot_q  <= res_plot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = m_valid_q && !m_tready_i;
  assign m_tvalid_o     = m_valid_q;
  assign m_glyph_o      = m_glyph_q;
  assign m_plotted_o    = m_plot_q;

endmodule

// ===== rtl/core/torus_point_zbuffer_shader.sv =====
// Plot runs the multiply steps, the divide (skipped when the depth saturates),
// projection, store lookup and compare. One item is worked on at a time,
// paced by the shared 24x24 multiplier and the bit-serial divider.
// Start sweeps all 1080 cells of the store, one cell a cycle, before its result.
// After reset the same clearing pass runs with s_axis_tready_o low;
// the projection scale resets to 15 and the frame rotation terms to zero.
`timescale 1ns / 1ps
`include "torus_point_zbuffer_shader_assert.svh"
module torus_point_zbuffer_shader (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [5:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sin_a, cos_a, sin_b, cos_b, sin_ring, cos_ring, sin_sweep, cos_sweep, cell_index.
  input  logic [143:0] s_axis_tdata_i,
  // action.
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // glyph.
  output logic [7:0]   m_axis_tdata_o,
  // plotted.
  output logic [0:0]   m_axis_tuser_o
);

  tpzs_pkg::cmd_t     cmd;
  tpzs_pkg::sts_t     sts;
  tpzs_pkg::ram_req_t ram_req;
  logic [tpzs_pkg::ENTRY_W-1:0] ram_rdata;

  tpzs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .action_i   (s_axis_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpzs_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sin_a_i      (s_axis_tdata_i[15:0]),
    .cos_a_i      (s_axis_tdata_i[31:16]),
    .sin_b_i      (s_axis_tdata_i[47:32]),
    .cos_b_i      (s_axis_tdata_i[63:48]),
    .sin_ring_i   (s_axis_tdata_i[79:64]),
    .cos_ring_i   (s_axis_tdata_i[95:80]),
    .sin_sweep_i  (s_axis_tdata_i[111:96]),
    .cos_sweep_i  (s_axis_tdata_i[127:112]),
    .cell_index_i (s_axis_tdata_i[138:128]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ram_o        (ram_req),
    .ram_rdata_i  (ram_rdata),
    .m_tready_i   (m_axis_tready_i),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_glyph_o    (m_axis_tdata_o),
    .m_plotted_o  (m_axis_tuser_o[0])
  );

  tpzs_ram #(
    .WIDTH (tpzs_pkg::ENTRY_W),
    .DEPTH (tpzs_pkg::CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  `TPZS_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `TPZS_ASSERT_IMP(a_no_write_when_idle, ram_req.we, !s_axis_tready_o)
  `TPZS_ASSERT_IMP(a_plot_has_glyph, m_axis_tvalid_o && m_axis_tuser_o[0],
                   m_axis_tdata_o != 8'h20 && m_axis_tdata_o != 8'h00)
  `TPZS_ASSERT_IMP(a_result_after_work, $rose(m_axis_tvalid_o), !$past(s_axis_tready_o))

endmodule
